// ===== sv/perlin_noise_2d_sample_unit_macros.svh =====
// Assertion macros used by the pipeline control of the noise sample unit RTL.
`ifndef PERLIN_NOISE_2D_SAMPLE_UNIT_MACROS_SVH
`define PERLIN_NOISE_2D_SAMPLE_UNIT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define PN2_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in this cycle implies the consequent in the next cycle.
`define PN2_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pn2_pkg.sv =====
// Shared types and constants for the 2D gradient noise sample pipeline.
package pn2_pkg;

  // pipeline depth and stage slots
  localparam int NSTG  = 8;
  localparam int ST_S1 = 0;
  localparam int ST_S2 = 1;
  localparam int ST_S3 = 2;
  localparam int ST_S4 = 3;
  localparam int ST_S5 = 4;
  localparam int ST_S6 = 5;
  localparam int ST_S7 = 6;
  localparam int ST_S8 = 7;

  // corner hash
  localparam logic [31:0] HASH_K1  = 32'd374761393;
  localparam logic [31:0] HASH_K2  = 32'd668265263;
  localparam logic [31:0] HASH_K3  = 32'd1274126177;
  localparam logic [31:0] HASH_K12 = HASH_K1 + HASH_K2;
  localparam int          SH1      = 13;
  localparam int          SH2      = 16;
  // only these low bits of the xor-shifted hash reach the gradient select
  localparam int          HG_W     = SH2 + 2;

  typedef enum logic [1:0] {
    GRAD_PP = 2'd0,  // dx + dy
    GRAD_NP = 2'd1,  // -dx + dy
    GRAD_PN = 2'd2,  // dx - dy
    GRAD_NN = 2'd3   // -dx - dy
  } grad_t;

  typedef struct packed {
    logic [NSTG-1:0] en;   // stage register load
    logic [NSTG-1:0] vld;  // stage holds an item
  } pipe_ctl_t;

endpackage

// ===== sv/pn2_ctrl.sv =====
// Valid chain and per-stage load enables with bubble collapsing.
`include "perlin_noise_2d_sample_unit_macros.svh"

module pn2_ctrl
  import pn2_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output pipe_ctl_t ctl
);

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] en;

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign vld_nxt = (vld_r & ~en) | ({vld_r[NSTG-2:0], in_valid} & en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];
  assign ctl.en    = en;
  assign ctl.vld   = vld_r;

  `PN2_ASSERT(a_full_when_blocked, (!in_ready |-> (vld_r == '1)), "input blocked with a bubble")
  `PN2_ASSERT(a_drain_frees_input, (out_ready |-> in_ready), "input blocked while output drains")
  `PN2_ASSERT_NEXT(a_count_up, in_valid && in_ready && !(out_valid && out_ready), $countones(vld_r) == $past($countones(vld_r)) + 1, "item lost on entry")
  `PN2_ASSERT_NEXT(a_count_down, !(in_valid && in_ready) && out_valid && out_ready, $countones(vld_r) + 1 == $past($countones(vld_r)), "item count wrong on exit")

endmodule

// ===== sv/pn2_hash.sv =====
// Corner hash pipeline: four corner hashes reduced to gradient selects.
module pn2_hash
  import pn2_pkg::*;
(
  input  logic        clk,
  input  pipe_ctl_t   ctl,
  input  logic [31:0] cx,
  input  logic [31:0] cy,
  output grad_t       grad [4]
);

  logic [31:0]     mx_nxt;
  logic [31:0]     my_nxt;
  logic [31:0]     mx_r;
  logic [31:0]     my_r;
  logic [31:0]     h00;
  logic [31:0]     h [4];
  logic [HG_W-1:0] g_nxt [4];
  logic [HG_W-1:0] g_r [4];
  logic [HG_W-1:0] p [4];
  grad_t           grad_nxt [4];
  grad_t           grad_r [4];

  // stage 1: (x0+1)*K1 = x0*K1 + K1, so one product per axis
  assign mx_nxt = cx * HASH_K1;
  assign my_nxt = cy * HASH_K2;

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S1]) begin
      mx_r <= mx_nxt;
      my_r <= my_nxt;
    end
  end

  // stage 2: sums for the four corners, first xor-shift on the low bits
  assign h00  = mx_r + my_r;
  assign h[0] = h00;
  assign h[1] = h00 + HASH_K1;
  assign h[2] = h00 + HASH_K2;
  assign h[3] = h00 + HASH_K12;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      g_nxt[k] = h[k][HG_W-1:0] ^ h[k][HG_W-1+SH1:SH1];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S2]) begin
      g_r <= g_nxt;
    end
  end

  // stage 3: low bits of the final multiply, then fold bits 17:16 down
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p[k]        = g_r[k] * HASH_K3[HG_W-1:0];
      grad_nxt[k] = grad_t'(p[k][1:0] ^ p[k][SH2+1:SH2]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S3]) begin
      grad_r <= grad_nxt;
    end
  end

  assign grad = grad_r;

endmodule

// ===== sv/pn2_fade.sv =====
// Quintic fade 6t^5-15t^4+10t^3 over three stages, offset carried along.
module pn2_fade
  import pn2_pkg::*;
#(
  parameter int F = 16
) (
  input  logic                clk,
  input  pipe_ctl_t           ctl,
  input  logic [F-1:0]        t,
  output logic [F-1:0]        t_o,
  output logic signed [F+1:0] fade
);

  localparam int AW  = F + 5;
  localparam int PW1 = 2 * F + 6;
  localparam int TW2 = 2 * F;
  localparam int CW  = F + 6;
  localparam int PW3 = 2 * F + 7;
  localparam logic signed [AW-1:0] FIFTEEN_ONE = AW'(15) << F;
  localparam logic signed [CW-1:0] TEN_ONE     = CW'(10) << F;

  logic signed [AW-1:0]  a;
  logic signed [F:0]     ts;
  logic signed [PW1-1:0] ta_nxt;
  logic [TW2-1:0]        tt_nxt;
  logic signed [PW1-1:0] ta_r;
  logic [TW2-1:0]        tt_r;
  logic [F-1:0]          tq1_r;
  logic signed [CW-1:0]  c_nxt;
  logic [F-1:0]          sq;
  logic [TW2-1:0]        t3p_nxt;
  logic signed [CW-1:0]  c_r;
  logic [TW2-1:0]        t3p_r;
  logic [F-1:0]          tq2_r;
  logic [F-1:0]          cube;
  logic signed [PW3-1:0] fp_nxt;
  logic signed [PW3-1:0] fp_r;
  logic [F-1:0]          tq3_r;

  // stage 1: t*(6t-15) and t*t
  assign a      = $signed(AW'(t) * AW'(6)) - FIFTEEN_ONE;
  assign ts     = $signed({1'b0, t});
  assign ta_nxt = PW1'(a) * PW1'(ts);
  assign tt_nxt = TW2'(t) * TW2'(t);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S1]) begin
      ta_r  <= ta_nxt;
      tt_r  <= tt_nxt;
      tq1_r <= t;
    end
  end

  // stage 2: c = b + 10, t^3 product
  assign c_nxt   = $signed(ta_r[PW1-1:F]) + TEN_ONE;
  assign sq      = tt_r[TW2-1:F];
  assign t3p_nxt = TW2'(sq) * TW2'(tq1_r);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S2]) begin
      c_r   <= c_nxt;
      t3p_r <= t3p_nxt;
      tq2_r <= tq1_r;
    end
  end

  // stage 3: t^3 * c
  assign cube   = t3p_r[TW2-1:F];
  assign fp_nxt = PW3'(c_r) * PW3'($signed({1'b0, cube}));

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S3]) begin
      fp_r  <= fp_nxt;
      tq3_r <= tq2_r;
    end
  end

  // fade stays within [0, 1.0]
  assign fade = $signed(fp_r[2*F+1:F]);
  assign t_o  = tq3_r;

endmodule

// ===== sv/pn2_blend.sv =====
// Corner gradient values and the two bilinear lerp levels, stages 4 to 8.
module pn2_blend
  import pn2_pkg::*;
#(
  parameter int F = 16
) (
  input  logic                clk,
  input  pipe_ctl_t           ctl,
  input  grad_t               grad [4],
  input  logic [F-1:0]        tx,
  input  logic [F-1:0]        ty,
  input  logic signed [F+1:0] u,
  input  logic signed [F+1:0] v,
  output logic signed [F+2:0] noise
);

  localparam int NW = F + 3;
  localparam int DW = F + 4;
  localparam int PW = 2 * F + 6;
  localparam int XW = F + 4;
  localparam int QW = 2 * F + 7;
  localparam int RW = F + 6;
  localparam int OW = F + 3;
  localparam logic signed [NW-1:0] ONE_N = NW'(1) << F;
  localparam logic signed [RW-1:0] TWO_R = RW'(2) << F;

  function automatic logic signed [NW-1:0] corner_val(input grad_t g,
                                                      input logic signed [NW-1:0] dx,
                                                      input logic signed [NW-1:0] dy);
    case (g)
      GRAD_PP: corner_val = dx + dy;
      GRAD_NP: corner_val = dy - dx;
      GRAD_PN: corner_val = dx - dy;
      default: corner_val = -dx - dy;
    endcase
  endfunction

  logic signed [NW-1:0]   dx0, dx1, dy0, dy1;
  logic signed [NW-1:0]   n00, n10, n01, n11;
  logic signed [NW-1:0]   n00_4_r, n01_4_r;
  logic signed [DW-1:0]   d0_4_r, d1_4_r;
  logic signed [F+1:0]    u4_r, v4_r;
  logic signed [PW-1:0]   p0_nxt, p1_nxt;
  logic signed [PW-1:0]   p0_r, p1_r;
  logic signed [NW-1:0]   n00_5_r, n01_5_r;
  logic signed [F+1:0]    v5_r;
  logic signed [XW-1:0]   nx0, nx1;
  logic signed [XW-1:0]   nx0_6_r;
  logic signed [XW:0]     dd_6_r;
  logic signed [F+1:0]    v6_r;
  logic signed [QW-1:0]   q_nxt;
  logic signed [QW-1:0]   q_r;
  logic signed [XW-1:0]   nx0_7_r;
  logic signed [RW-1:0]   r;
  logic signed [RW-1:0]   r_sat;
  logic signed [OW-1:0]   noise_r;

  // stage 4: corner values and lerp differences
  assign dx0 = $signed(NW'(tx));
  assign dy0 = $signed(NW'(ty));
  assign dx1 = dx0 - ONE_N;
  assign dy1 = dy0 - ONE_N;
  assign n00 = corner_val(grad[0], dx0, dy0);
  assign n10 = corner_val(grad[1], dx1, dy0);
  assign n01 = corner_val(grad[2], dx0, dy1);
  assign n11 = corner_val(grad[3], dx1, dy1);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S4]) begin
      n00_4_r <= n00;
      n01_4_r <= n01;
      d0_4_r  <= DW'(n10) - DW'(n00);
      d1_4_r  <= DW'(n11) - DW'(n01);
      u4_r    <= u;
      v4_r    <= v;
    end
  end

  // stage 5: u * (b - a) for both rows
  assign p0_nxt = PW'(u4_r) * PW'(d0_4_r);
  assign p1_nxt = PW'(u4_r) * PW'(d1_4_r);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S5]) begin
      p0_r    <= p0_nxt;
      p1_r    <= p1_nxt;
      n00_5_r <= n00_4_r;
      n01_5_r <= n01_4_r;
      v5_r    <= v4_r;
    end
  end

  // stage 6: row results lie between their corners
  assign nx0 = XW'(n00_5_r) + XW'($signed(p0_r[PW-1:F]));
  assign nx1 = XW'(n01_5_r) + XW'($signed(p1_r[PW-1:F]));

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S6]) begin
      nx0_6_r <= nx0;
      dd_6_r  <= (XW+1)'(nx1) - (XW+1)'(nx0);
      v6_r    <= v5_r;
    end
  end

  // stage 7: v * (nx1 - nx0)
  assign q_nxt = QW'(v6_r) * QW'(dd_6_r);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S7]) begin
      q_r     <= q_nxt;
      nx0_7_r <= nx0_6_r;
    end
  end

  // stage 8: final sum, clamp to +/-2.0
  assign r = RW'(nx0_7_r) + RW'($signed(q_r[QW-1:F]));

  always_comb begin
    if (r > TWO_R) begin
      r_sat = TWO_R;
    end else if (r < -TWO_R) begin
      r_sat = -TWO_R;
    end else begin
      r_sat = r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_S8]) begin
      noise_r <= OW'(r_sat);
    end
  end

  assign noise = noise_r;

endmodule

// ===== sv/perlin_noise_2d_sample_unit.sv =====
// Top level of the pipelined 2D gradient noise sample unit.
// Eight register stages, S1 to S8; out_valid is the valid bit of the last stage.
// Throughput: one item per cycle until out_ready low holds a full pipeline; a stage loads when
// empty or when the next moves, so bubbles close up and input flows while a result waits.
// Reset (rst_n low, synchronous) clears only the stage valid bits; data registers
// are not reset.
module perlin_noise_2d_sample_unit
  import pn2_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [31:0]          in_coord_x,
  input  logic signed [31:0]          in_coord_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [FRAC_BITS+2:0] out_noise
);

  localparam int CB = INT_BITS + FRAC_BITS;
  localparam int EW = (CB > 32) ? CB : 32;

  pipe_ctl_t                  ctl;
  logic [EW-1:0]              xe, ye;
  logic [INT_BITS-1:0]        xi, yi;
  logic [31:0]                cx, cy;
  logic [FRAC_BITS-1:0]       xf, yf;
  logic [FRAC_BITS-1:0]       tx, ty;
  logic signed [FRAC_BITS+1:0] u, v;
  grad_t                      grad [4];

  // only the low CB bits of a coordinate count, sign-extended from there
  assign xe = EW'($unsigned(in_coord_x));
  assign ye = EW'($unsigned(in_coord_y));
  assign xi = xe[CB-1:FRAC_BITS];
  assign yi = ye[CB-1:FRAC_BITS];
  assign xf = xe[FRAC_BITS-1:0];
  assign yf = ye[FRAC_BITS-1:0];
  assign cx = {{(32-INT_BITS){xi[INT_BITS-1]}}, xi};
  assign cy = {{(32-INT_BITS){yi[INT_BITS-1]}}, yi};

  pn2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  pn2_hash u_hash (
    .clk  (clk),
    .ctl  (ctl),
    .cx   (cx),
    .cy   (cy),
    .grad (grad)
  );

  pn2_fade #(.F(FRAC_BITS)) u_fade_x (
    .clk  (clk),
    .ctl  (ctl),
    .t    (xf),
    .t_o  (tx),
    .fade (u)
  );

  pn2_fade #(.F(FRAC_BITS)) u_fade_y (
    .clk  (clk),
    .ctl  (ctl),
    .t    (yf),
    .t_o  (ty),
    .fade (v)
  );

  pn2_blend #(.F(FRAC_BITS)) u_blend (
    .clk   (clk),
    .ctl   (ctl),
    .grad  (grad),
    .tx    (tx),
    .ty    (ty),
    .u     (u),
    .v     (v),
    .noise (out_noise)
  );

endmodule

// ===== verif/perlin_noise_2d_sample_unit_test.sv =====
// Self-checking testbench for the 2D gradient noise sample unit.
module perlin_noise_2d_sample_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pn2_pkg::*;

  localparam int          FB     = 16;
  localparam int          OUT_W  = FB + 3;
  localparam longint      ONE_FX = 64'sd1 << FB;
  localparam logic [31:0] MIX_X  = 32'd374761393;
  localparam logic [31:0] MIX_Y  = 32'd668265263;
  localparam logic [31:0] MIX_Z  = 32'd1274126177;
  localparam int          DRAIN_CYCLES = 16;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [31:0]      in_coord_x = '0;
  logic signed [31:0]      in_coord_y = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_noise;

  logic [OUT_W-1:0] noise_due[$];
  int unsigned      n_errors = 0;
  bit               send_idle = 1'b0;
  bit               recv_stall = 1'b0;

  perlin_noise_2d_sample_unit #(
    .FRAC_BITS(FB),
    .INT_BITS (16)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_coord_x(in_coord_x),
    .in_coord_y(in_coord_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_noise (out_noise)
  );

  always #1 clk = ~clk;

  // ---------------- noise predictor ----------------

  function automatic grad_t corner_grad(longint cx, longint cy);
    logic [31:0] ux;
    logic [31:0] uy;
    logic [31:0] h;
    ux = cx[31:0];
    uy = cy[31:0];
    h = ux * MIX_X + uy * MIX_Y;
    h = (h ^ (h >> 13)) * MIX_Z;
    h = h ^ (h >> 16);
    return grad_t'(h[1:0]);
  endfunction

  function automatic longint corner_value(longint cx, longint cy, longint dx, longint dy);
    case (corner_grad(cx, cy))
      GRAD_PP: return dx + dy;
      GRAD_NP: return -dx + dy;
      GRAD_PN: return dx - dy;
      default: return -dx - dy;
    endcase
  endfunction

  // quintic fade, every product truncated toward minus infinity
  function automatic longint fade_of(longint t);
    longint a;
    longint b;
    longint c;
    longint t2;
    longint t3;
    a  = 6 * t - 15 * ONE_FX;
    b  = (t * a) >>> FB;
    c  = b + 10 * ONE_FX;
    t2 = (t * t) >>> FB;
    t3 = (t2 * t) >>> FB;
    return (t3 * c) >>> FB;
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + ((t * (b - a)) >>> FB);
  endfunction

  function automatic logic [OUT_W-1:0] noise_of(logic [31:0] cx, logic [31:0] cy);
    longint px;
    longint py;
    longint x0;
    longint y0;
    longint xf;
    longint yf;
    longint n00;
    longint n10;
    longint n01;
    longint n11;
    longint u;
    longint v;
    longint r;
    px  = longint'($signed(cx));
    py  = longint'($signed(cy));
    x0  = px >>> FB;
    y0  = py >>> FB;
    xf  = px & (ONE_FX - 1);
    yf  = py & (ONE_FX - 1);
    n00 = corner_value(x0,     y0,     xf,          yf);
    n10 = corner_value(x0 + 1, y0,     xf - ONE_FX, yf);
    n01 = corner_value(x0,     y0 + 1, xf,          yf - ONE_FX);
    n11 = corner_value(x0 + 1, y0 + 1, xf - ONE_FX, yf - ONE_FX);
    u   = fade_of(xf);
    v   = fade_of(yf);
    r   = blend(blend(n00, n10, u), blend(n01, n11, u), v);
    if (r > 2 * ONE_FX) r = 2 * ONE_FX;
    if (r < -2 * ONE_FX) r = -2 * ONE_FX;
    return r[OUT_W-1:0];
  endfunction

  // ---------------- stimulus helpers ----------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return $urandom_range(0, 2);
    if (pick < 9) return $urandom_range(3, 8);
    return $urandom_range(9, 40);
  endfunction

  function automatic logic [31:0] rand_coord();
    logic [15:0] edge_frac [5] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFE, 16'hFFFF};
    logic [15:0] edge_int  [4] = '{16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000};
    logic [15:0] ip;
    logic [15:0] fp;
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom();
      3, 4: begin
        ip = 16'($urandom_range(0, 15)) - 16'd8;
        fp = 16'($urandom());
      end
      5: begin
        ip = 16'($urandom());
        fp = edge_frac[$urandom_range(0, 4)];
      end
      6: begin
        ip = edge_int[$urandom_range(0, 3)];
        fp = 16'($urandom());
      end
      default: begin
        ip = edge_int[$urandom_range(0, 3)];
        fp = edge_frac[$urandom_range(0, 4)];
      end
    endcase
    return {ip, fp};
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_coord(input logic [31:0] x, input logic [31:0] y);
    int unsigned gap;
    gap = send_idle ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_coord_x <= x;
    in_coord_y <= y;
    do @(posedge clk); while (!in_ready);
    noise_due.push_back(noise_of(x, y));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (noise_due.size() != 0);
  endtask

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // ---------------- result checker ----------------

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (noise_due.size() == 0) begin
        flag_error($sformatf("result with nothing expected, noise=%0d", out_noise));
      end else begin
        logic [OUT_W-1:0] want;
        want = noise_due.pop_front();
        if (out_noise !== want)
          flag_error($sformatf("noise expected %0d (0x%05h) got %0d (0x%05h)",
                               $signed(want), want, out_noise, out_noise));
      end
    end
  end

  // receiver: free running or stalling at random
  initial begin
    forever begin
      if (!recv_stall) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_ready <= 1'b0;
        repeat (1 + gap_len()) @(negedge clk);
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_corner_cases();
    int i;
    send_coord(32'h0000_0000, 32'h0000_0000);
    send_coord(32'h0001_0000, 32'h0003_0000);   // exact lattice point
    send_coord(32'h0000_FFFF, 32'h0000_FFFF);   // largest fraction
    send_coord(32'h0000_8000, 32'h0000_8000);
    send_coord(32'h7FFF_FFFF, 32'h7FFF_FFFF);   // x0+1 and y0+1 leave the coordinate range
    send_coord(32'h8000_0000, 32'h8000_0000);   // most negative
    send_coord(32'h7FFF_FFFF, 32'h8000_0000);
    send_coord(32'h8000_0000, 32'h7FFF_FFFF);
    send_coord(32'hFFFF_FFFF, 32'hFFFF_FFFF);   // just below the origin
    send_coord(32'hFFFF_0000, 32'h0000_0001);
    send_coord(32'h7FFF_8000, 32'hFFFF_FFFF);
    send_coord(32'h5555_AAAA, 32'hAAAA_5555);
    // neighboring cells so that every gradient shows up
    for (i = 0; i < 8; i++)
      send_coord({16'(i % 4) - 16'd2, 16'h4000}, {16'(i / 4), 16'hC000});
  endtask

  task automatic test_random_stream(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if (i % 64 == 0) begin
        send_idle  = $urandom_range(0, 3) != 0;
        recv_stall = $urandom_range(0, 3) != 0;
      end
      send_coord(rand_coord(), rand_coord());
    end
  endtask

  task automatic test_back_to_back(input int n);
    int i;
    send_idle  = 1'b0;
    recv_stall = 1'b0;
    for (i = 0; i < n; i++) send_coord($urandom(), $urandom());
  endtask

  task automatic test_pause_for_drain(input int n);
    int i;
    send_idle  = 1'b1;
    recv_stall = 1'b1;
    for (i = 0; i < n; i++) begin
      send_coord(rand_coord(), rand_coord());
      if (i % 25 == 24) wait_drained();
    end
  endtask

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_corner_cases();
    test_random_stream(600);
    test_back_to_back(200);
    test_pause_for_drain(100);
    test_random_stream(130);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (noise_due.size() != 0) flag_error("results missing at end of run");
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pn2_pkg.sv
sv/pn2_ctrl.sv
sv/pn2_hash.sv
sv/pn2_fade.sv
sv/pn2_blend.sv
sv/perlin_noise_2d_sample_unit.sv
verif/perlin_noise_2d_sample_unit_test.sv
